[design/bot_pkg.sv]
// ============================================================================
// bot_pkg: shared types and constants for the bitmap orientation block
// Field widths, orientation codes, request kinds and sequencer states.
// ============================================================================
package bot_pkg;

    localparam int SIDE_DEF  = 256;
    localparam int ROW_W     = 8;
    localparam int BCOL_W    = 5;
    localparam int DATA_W    = 8;
    localparam int ORIENT_W  = 3;
    localparam int PIX_IDX_W = 3;

    localparam logic [DATA_W-1:0] LEFT_BIT = 8'h80;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [ORIENT_W-1:0] {
        OR_IDENT    = 3'd0,
        OR_ROT90    = 3'd1,
        OR_ROT180   = 3'd2,
        OR_ROT270   = 3'd3,
        OR_ROW_MIR  = 3'd4,
        OR_COL_MIR  = 3'd5,
        OR_TRANS    = 3'd6,
        OR_ANTI     = 3'd7
    } t_orient;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

endpackage

[design/bitmap_orientation_transform_top.sv]
// ============================================================================
// bitmap_orientation_transform_top: oriented view of a square 1-bit image
// Stores bytes of the image and returns bytes in one of eight orientations.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: i_action
//   selects a write of i_write_data at (i_row, i_byte_col) or a read of the
//   byte at that place as seen in the current orientation.
//   Output channel (o_out_valid / i_out_stall) carries o_read_data, one per
//   read request; writes give no result. Orientation register: written by
//   i_cfg_we / i_cfg_wdata; user writes only while idle; block doesn't check.
// Timing:
//   A write is done in the cycle it is accepted; the next request can be
//   taken in the next cycle. A read makes eight single-port store reads,
//   one per pixel, through the shared coordinate map unit, then gathers the
//   last pixel and hands the byte to the output register, which raises
//   o_out_valid; then the block takes the next request.
// Reset (i_rst_n low, synchronous): orientation back to identity, no
//   pending result; the image store is not cleared.
// Stall: the output register holds a result while i_out_stall is high; new
//   writes are still taken, a finished read waits in the sequencer.
// ============================================================================
module bitmap_orientation_transform_top #(
    parameter int SIDE = bot_pkg::SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  logic [bot_pkg::ROW_W-1:0]      i_row,
    input  logic [bot_pkg::BCOL_W-1:0]     i_byte_col,
    input  logic [bot_pkg::DATA_W-1:0]     i_write_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bot_pkg::DATA_W-1:0]     o_read_data,
    input  logic                           i_cfg_we,
    input  logic [bot_pkg::ORIENT_W-1:0]   i_cfg_wdata
);
    import bot_pkg::*;

    localparam int ROW_BYTES = (SIDE + 7) / 8;
    localparam int DEPTH     = SIDE * ROW_BYTES;
    localparam int AW        = $clog2(DEPTH);

    t_orient              r_orient;
    logic                 r_out_valid;
    logic [DATA_W-1:0]    r_out_data;

    // sequencer <-> map unit
    t_orient              map_orient;
    logic [ROW_W-1:0]     map_row;
    logic [BCOL_W-1:0]    map_bcol;
    logic [PIX_IDX_W-1:0] map_k;
    logic                 map_in_range;
    logic [AW-1:0]        map_addr;
    logic [PIX_IDX_W-1:0] map_bit;
    logic                 map_ok;

    logic                 ram_en;
    logic                 ram_we;
    logic [DATA_W-1:0]    ram_rdata;

    logic                 res_valid;
    logic [DATA_W-1:0]    res_data;
    logic                 res_take;

    // orientation register: user writes only while idle; block does not check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= OR_IDENT;
        end else if (i_cfg_we) begin
            r_orient <= t_orient'(i_cfg_wdata);
        end
    end

    bot_seq #(.SIDE(SIDE)) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_row          (i_row),
        .i_byte_col     (i_byte_col),
        .i_orient       (r_orient),
        .o_map_orient   (map_orient),
        .o_map_row      (map_row),
        .o_map_bcol     (map_bcol),
        .o_map_k        (map_k),
        .o_map_in_range (map_in_range),
        .i_map_bit      (map_bit),
        .i_map_ok       (map_ok),
        .o_ram_en       (ram_en),
        .o_ram_we       (ram_we),
        .i_ram_rdata    (ram_rdata),
        .o_res_valid    (res_valid),
        .o_res_data     (res_data),
        .i_res_take     (res_take)
    );

    // one map unit serves both write addressing and every read pixel
    bot_coord_map #(.SIDE(SIDE)) u_map (
        .i_orient   (map_orient),
        .i_row      (map_row),
        .i_bcol     (map_bcol),
        .i_k        (map_k),
        .i_in_range (map_in_range),
        .o_addr     (map_addr),
        .o_bit      (map_bit),
        .o_ok       (map_ok)
    );

    bot_image_ram #(.DEPTH(DEPTH), .DW(DATA_W)) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (map_addr),
        .i_wdata (i_write_data),
        .o_rdata (ram_rdata)
    );

    // output register: takes a new byte when empty or being drained
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take && res_valid) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

[design/bot_image_ram.sv]
// ============================================================================
// bot_image_ram: single-port image store
// One access per cycle, write or registered read.
// ============================================================================
module bot_image_ram #(
    parameter int DEPTH = 8192,
    parameter int DW    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DW-1:0]            i_wdata,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/bot_coord_map.sv]
// ============================================================================
// bot_coord_map: shared coordinate and address unit
// Maps one output pixel to its source pixel and the store address.
// ============================================================================
module bot_coord_map #(
    parameter int SIDE = 256
) (
    input  bot_pkg::t_orient                   i_orient,
    input  logic [bot_pkg::ROW_W-1:0]          i_row,
    input  logic [bot_pkg::BCOL_W-1:0]         i_bcol,
    input  logic [bot_pkg::PIX_IDX_W-1:0]      i_k,
    input  logic                               i_in_range,
    output logic [$clog2(SIDE*((SIDE+7)/8))-1:0] o_addr,
    output logic [bot_pkg::PIX_IDX_W-1:0]      o_bit,
    output logic                               o_ok
);
    import bot_pkg::*;

    localparam int CW        = $clog2(SIDE);
    localparam int XW        = CW + 1;
    localparam int ROW_BYTES = (SIDE + 7) / 8;
    localparam int AW        = $clog2(SIDE * ROW_BYTES);
    localparam logic [CW-1:0] MAX_C = CW'(SIDE - 1);
    localparam logic [AW-1:0] RB    = AW'(ROW_BYTES);

    logic [XW-1:0] xw;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] sc;
    logic [CW-1:0] sr;

    assign xw = XW'({i_bcol, i_k});
    assign x  = xw[CW-1:0];
    assign y  = CW'(i_row);
    // pixels past the right edge read as zero
    assign o_ok = i_in_range && (xw < XW'(SIDE));

    always_comb begin
        unique case (i_orient)
            OR_IDENT:   begin sc = x;         sr = y;         end
            OR_ROT90:   begin sc = y;         sr = MAX_C - x; end
            OR_ROT180:  begin sc = MAX_C - x; sr = MAX_C - y; end
            OR_ROT270:  begin sc = MAX_C - y; sr = x;         end
            OR_ROW_MIR: begin sc = x;         sr = MAX_C - y; end
            OR_COL_MIR: begin sc = MAX_C - x; sr = y;         end
            OR_TRANS:   begin sc = y;         sr = x;         end
            OR_ANTI:    begin sc = MAX_C - y; sr = MAX_C - x; end
            default:    begin sc = x;         sr = y;         end
        endcase
    end

    assign o_addr = AW'(sr) * RB + AW'(sc >> 3);
    assign o_bit  = sc[PIX_IDX_W-1:0];

endmodule

[design/bot_seq.sv]
// ============================================================================
// bot_seq: request sequencer
// Takes requests, steps the shared map unit over eight pixels, gathers bits.
// ============================================================================
module bot_seq #(
    parameter int SIDE = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_action,
    input  logic [bot_pkg::ROW_W-1:0]      i_row,
    input  logic [bot_pkg::BCOL_W-1:0]     i_byte_col,
    input  bot_pkg::t_orient               i_orient,
    output bot_pkg::t_orient               o_map_orient,
    output logic [bot_pkg::ROW_W-1:0]      o_map_row,
    output logic [bot_pkg::BCOL_W-1:0]     o_map_bcol,
    output logic [bot_pkg::PIX_IDX_W-1:0]  o_map_k,
    output logic                           o_map_in_range,
    input  logic [bot_pkg::PIX_IDX_W-1:0]  i_map_bit,
    input  logic                           i_map_ok,
    output logic                           o_ram_en,
    output logic                           o_ram_we,
    input  logic [bot_pkg::DATA_W-1:0]     i_ram_rdata,
    output logic                           o_res_valid,
    output logic [bot_pkg::DATA_W-1:0]     o_res_data,
    input  logic                           i_res_take
);
    import bot_pkg::*;

    localparam int ROW_BYTES = (SIDE + 7) / 8;

    t_state                  r_state, n_state;
    logic [PIX_IDX_W:0]      r_k, n_k;
    logic                    r_pv, n_pv;
    logic [PIX_IDX_W-1:0]    r_pk;
    logic [PIX_IDX_W-1:0]    r_pbit;
    logic                    r_pok;
    logic [DATA_W-1:0]       r_acc;
    logic [ROW_W-1:0]        r_row;
    logic [BCOL_W-1:0]       r_bcol;
    logic                    r_in_range;

    logic idle;
    logic accept;
    logic in_range_now;

    assign idle         = (r_state == S_IDLE);
    assign accept       = i_in_valid && idle;
    assign in_range_now = (32'(i_row) < SIDE) && (32'(i_byte_col) < ROW_BYTES);

    assign o_in_stall = !idle;

    // idle: map unit computes the write address; running: the source pixel
    always_comb begin
        if (idle) begin
            o_map_orient   = OR_IDENT;
            o_map_row      = i_row;
            o_map_bcol     = i_byte_col;
            o_map_k        = '0;
            o_map_in_range = in_range_now;
        end else begin
            o_map_orient   = i_orient;
            o_map_row      = r_row;
            o_map_bcol     = r_bcol;
            o_map_k        = r_k[PIX_IDX_W-1:0];
            o_map_in_range = r_in_range;
        end
    end

    assign o_ram_we = accept && (i_action == ACT_WRITE) && in_range_now;
    assign o_ram_en = o_ram_we || ((r_state == S_RUN) && !r_k[PIX_IDX_W]);

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_pv    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_READ)) begin
                    n_state = S_RUN;
                    n_k     = '0;
                end
            end
            S_RUN: begin
                if (r_k[PIX_IDX_W]) begin
                    n_state = S_HOLD;
                end else begin
                    n_k  = r_k + 1'b1;
                    n_pv = 1'b1;
                end
            end
            S_HOLD: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row      <= i_row;
            r_bcol     <= i_byte_col;
            r_in_range <= in_range_now;
        end
        r_pk   <= r_k[PIX_IDX_W-1:0];
        r_pbit <= i_map_bit;
        r_pok  <= i_map_ok;
        // bit 7 holds pixel 0, so the index is the complement
        if (r_pv) begin
            r_acc[~r_pk] <= r_pok && ((i_ram_rdata & (LEFT_BIT >> r_pbit)) != '0);
        end
    end

    assign o_res_valid = (r_state == S_HOLD);
    assign o_res_data  = r_acc;

endmodule

[design/bot_checker.sv]
// ============================================================================
// bot_checker: port-level assertions for the orientation block
// Watches request acceptance, stalling and reset at the top-level ports.
// ============================================================================
module bot_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           i_action,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [bot_pkg::DATA_W-1:0]     o_read_data
);
    import bot_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    // a read request occupies the block for the following cycle
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_READ)) |=> o_in_stall)
        else $error("read request did not occupy the block");

    // a write request completes in its own cycle
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_WRITE)) |=> !o_in_stall)
        else $error("write request left the block busy");

    // reset leaves no pending result and the input open
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("state not cleared by reset");

    // stalled result stays with its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_read_data)))
        else $error("stalled result changed");

endmodule

bind bitmap_orientation_transform_top bot_checker u_bot_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_action    (i_action),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_read_data (o_read_data)
);

[test/bitmap_orientation_transform_top_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// bitmap_orientation_transform_top_tb: self-checking bench for the image view
// First fills the whole 256x256 image with random bytes. Then it runs a short
// table of corner requests through all eight orientations. Random request
// phases follow, each under its own orientation. Every read result is checked
// against a typed value or a local bit-level model of the stored image.
// ============================================================================
module bitmap_orientation_transform_top_tb;
    import bot_pkg::*;

    localparam int SIDE      = 256;
    localparam int EDGE_MAX  = SIDE - 1;
    localparam int ROW_BYTES = SIDE / 8;
    localparam int PHASES    = 8;
    localparam int PHASE_REQ = 100;
    localparam int DRAIN_CYC = 16;   // pause for a read still in the block
    localparam int DIR_ROWS  = 24;

    // one row of the directed table; typed_val is used only when typed_ok
    typedef struct packed {
        logic               action;
        logic [ROW_W-1:0]   row;
        logic [BCOL_W-1:0]  bcol;
        logic [DATA_W-1:0]  data;
        t_orient            view;
        logic               typed_ok;
        logic [DATA_W-1:0]  typed_val;
    } t_dir_req;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_action;
    logic [ROW_W-1:0]     i_row;
    logic [BCOL_W-1:0]    i_byte_col;
    logic [DATA_W-1:0]    i_write_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [DATA_W-1:0]    o_read_data;
    logic                 i_cfg_we;
    logic [ORIENT_W-1:0]  i_cfg_wdata;

    // local copy of the image and of the orientation register
    logic [DATA_W-1:0]    image_mem [0:SIDE*ROW_BYTES-1];
    t_orient              cur_view;
    logic [DATA_W-1:0]    pending_bytes [$];   // read results still owed
    int                   fail_count;
    bit                   src_gaps_on;         // sender inserts gaps
    bit                   sink_stall_on;       // receiver inserts stalls
    t_dir_req             dir_table [DIR_ROWS];

    bitmap_orientation_transform_top #(
        .SIDE(SIDE)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_byte_col   (i_byte_col),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hang guard: far above the slowest legal run (fill + ~850 requests,
    // each with worst gaps, reads and worst output stalls).
    initial begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

    // Byte at (row, bcol) of the oriented view. Output pixel (x, y) maps to
    // a source pixel (sx, sy) of the stored image; EDGE_MAX is the last index.
    function automatic logic [DATA_W-1:0] oriented_byte(input t_orient view,
                                                        input int row,
                                                        input int bcol);
        int x;
        int sx;
        int sy;
        int k;
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] src;
        acc = '0;
        for (k = 0; k < 8; k++) begin
            x = bcol * 8 + k;
            case (view)
                OR_ROT90:   begin sx = row;            sy = EDGE_MAX - x;   end
                OR_ROT180:  begin sx = EDGE_MAX - x;   sy = EDGE_MAX - row; end
                OR_ROT270:  begin sx = EDGE_MAX - row; sy = x;              end
                OR_ROW_MIR: begin sx = x;              sy = EDGE_MAX - row; end
                OR_COL_MIR: begin sx = EDGE_MAX - x;   sy = row;            end
                OR_TRANS:   begin sx = row;            sy = x;              end
                OR_ANTI:    begin sx = EDGE_MAX - row; sy = EDGE_MAX - x;   end
                default:    begin sx = x;              sy = row;            end
            endcase
            src = image_mem[sy * ROW_BYTES + sx / 8];
            // stored bytes are MSB-first: pixel 0 of a byte sits in bit 7
            if ((src & (LEFT_BIT >> (sx % 8))) != 0)
                acc = acc | (LEFT_BIT >> k);
        end
        return acc;
    endfunction

    // Drive one request, starting and ending at a falling edge. Valid stays
    // high across back-to-back requests; it drops only for a sender gap.
    task automatic issue_request(input logic act,
                                 input logic [ROW_W-1:0] row,
                                 input logic [BCOL_W-1:0] bcol,
                                 input logic [DATA_W-1:0] data,
                                 input logic typed_ok,
                                 input logic [DATA_W-1:0] typed_val);
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_row        <= row;
        i_byte_col   <= bcol;
        i_write_data <= data;
        // request is taken at the first rising edge with stall low
        do @(posedge i_clk); while (o_in_stall);
        if (act == ACT_WRITE)
            image_mem[row * ROW_BYTES + bcol] = data;
        else if (typed_ok)
            pending_bytes.push_back(typed_val);
        else
            pending_bytes.push_back(oriented_byte(cur_view, row, bcol));
        @(negedge i_clk);
    endtask

    // Block must be idle for a register write: no reads owed, plus a pause
    // for any read still inside the sequencer.
    task automatic set_orientation(input t_orient view);
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= view;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_view     = view;
    endtask

    // Receiver: random stall bursts while enabled
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && sink_stall_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Result checker: each accepted byte against the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                $error("read_data: no result expected, actual %h", o_read_data);
                fail_count++;
            end else begin
                if (o_read_data !== pending_bytes[0]) begin
                    $error("read_data mismatch: expected %h, actual %h",
                           pending_bytes[0], o_read_data);
                    fail_count++;
                end
                void'(pending_bytes.pop_front());
            end
        end
    end

    // Main sequence
    initial begin
        int r;
        int c;
        int i;
        int p;
        logic act;
        logic [ROW_W-1:0] rr;
        logic [BCOL_W-1:0] cc;
        t_orient view;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = ACT_WRITE;
        i_row         = '0;
        i_byte_col    = '0;
        i_write_data  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = OR_IDENT;
        cur_view      = OR_IDENT;
        fail_count    = 0;
        src_gaps_on   = 1'b1;
        sink_stall_on = 1'b1;

        // Corner requests. Typed results: after a write the identity view
        // returns the byte itself; the 180 and mirror views at the corners
        // land on the bytes written just before, read off by hand.
        dir_table = '{
            '{ACT_WRITE, 8'd0,   5'd0,  8'hFF, OR_IDENT,   1'b0, 8'h00},
            '{ACT_READ,  8'd0,   5'd0,  8'h00, OR_IDENT,   1'b1, 8'hFF},
            '{ACT_WRITE, 8'd255, 5'd31, 8'h00, OR_IDENT,   1'b0, 8'h00},
            '{ACT_READ,  8'd255, 5'd31, 8'hFF, OR_IDENT,   1'b1, 8'h00},
            '{ACT_WRITE, 8'd0,   5'd31, 8'h80, OR_IDENT,   1'b0, 8'h00},
            '{ACT_READ,  8'd0,   5'd31, 8'h00, OR_IDENT,   1'b1, 8'h80},
            '{ACT_WRITE, 8'd255, 5'd0,  8'h01, OR_IDENT,   1'b0, 8'h00},
            '{ACT_READ,  8'd255, 5'd0,  8'h00, OR_IDENT,   1'b1, 8'h01},
            '{ACT_READ,  8'd0,   5'd0,  8'h00, OR_ROT90,   1'b0, 8'h00},
            '{ACT_READ,  8'd255, 5'd31, 8'h00, OR_ROT90,   1'b0, 8'h00},
            '{ACT_READ,  8'd0,   5'd0,  8'h00, OR_ROT180,  1'b1, 8'h00},
            '{ACT_READ,  8'd255, 5'd31, 8'h00, OR_ROT180,  1'b1, 8'hFF},
            '{ACT_READ,  8'd0,   5'd0,  8'h00, OR_ROT270,  1'b0, 8'h00},
            '{ACT_READ,  8'd128, 5'd16, 8'h00, OR_ROT270,  1'b0, 8'h00},
            '{ACT_READ,  8'd0,   5'd0,  8'h00, OR_ROW_MIR, 1'b1, 8'h01},
            '{ACT_READ,  8'd255, 5'd31, 8'h00, OR_ROW_MIR, 1'b1, 8'h80},
            '{ACT_READ,  8'd0,   5'd0,  8'h00, OR_COL_MIR, 1'b1, 8'h01},
            '{ACT_READ,  8'd0,   5'd31, 8'h00, OR_COL_MIR, 1'b1, 8'hFF},
            '{ACT_READ,  8'd0,   5'd0,  8'h00, OR_TRANS,   1'b0, 8'h00},
            '{ACT_READ,  8'd255, 5'd31, 8'h00, OR_TRANS,   1'b0, 8'h00},
            '{ACT_READ,  8'd100, 5'd13, 8'h00, OR_ANTI,    1'b0, 8'h00},
            '{ACT_READ,  8'd0,   5'd0,  8'h00, OR_ANTI,    1'b0, 8'h00},
            '{ACT_WRITE, 8'd7,   5'd3,  8'h5A, OR_ANTI,    1'b0, 8'h00},
            '{ACT_READ,  8'd231, 5'd0,  8'h00, OR_ANTI,    1'b0, 8'h00}
        };

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill the whole image first: transposing views gather pixels from
        // eight different bytes, so no read may come before this is done.
        for (r = 0; r < SIDE; r++)
            for (c = 0; c < ROW_BYTES; c++)
                issue_request(ACT_WRITE, r[ROW_W-1:0], c[BCOL_W-1:0],
                              DATA_W'($urandom_range(0, 255)), 1'b0, 8'h00);

        // Directed table; orientation changes only between rows, when idle
        for (i = 0; i < DIR_ROWS; i++) begin
            if (dir_table[i].view != cur_view)
                set_orientation(dir_table[i].view);
            issue_request(dir_table[i].action, dir_table[i].row, dir_table[i].bcol,
                          dir_table[i].data, dir_table[i].typed_ok,
                          dir_table[i].typed_val);
        end

        // Random phases: first two at the register extremes, the rest random.
        // The last phase runs with no gaps and no stalls.
        for (p = 0; p < PHASES; p++) begin
            if (p == 0)
                view = OR_IDENT;
            else if (p == 1)
                view = OR_ANTI;
            else
                view = t_orient'($urandom_range(0, 7));
            set_orientation(view);
            src_gaps_on   = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_stall_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (i = 0; i < PHASE_REQ; i++) begin
                act = ($urandom_range(0, 9) < 6) ? ACT_READ : ACT_WRITE;
                case ($urandom_range(0, 9))
                    0:       rr = '0;
                    1:       rr = '1;
                    default: rr = ROW_W'($urandom_range(0, SIDE - 1));
                endcase
                case ($urandom_range(0, 9))
                    0:       cc = '0;
                    1:       cc = '1;
                    default: cc = BCOL_W'($urandom_range(0, ROW_BYTES - 1));
                endcase
                issue_request(act, rr, cc, DATA_W'($urandom_range(0, 255)),
                              1'b0, 8'h00);
            end
        end

        // Drain: every owed read result, then a pause for stray output
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[bitmap_orientation_transform_top.f]
design/bot_pkg.sv
design/bot_image_ram.sv
design/bot_coord_map.sv
design/bot_seq.sv
design/bitmap_orientation_transform_top.sv
design/bot_checker.sv
test/bitmap_orientation_transform_top_tb.sv
